// ===== src/ttw_pkg.sv =====
// shared constants, codes and types of the text terminal writer
package ttw_pkg;

   // default screen geometry
   localparam int DEF_ROWS = 25;
   localparam int DEF_COLS = 80;

   // request actions
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // character codes
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // attribute after reset and the matching blank cell
   localparam logic [7:0]  ATTR_RESET  = 8'h0F;
   localparam logic [15:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

   // sequencer states
   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PUT,
      S_READ,
      S_RDATA,
      S_SCROLL,
      S_SWEEP,
      S_DONE
   } ttw_state_type;

   // one response as it leaves the sequencer
   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
   } ttw_result_type;

endpackage

// ===== src/ttw_ram.sv =====
// generic single write port ram with registered read
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/ttw_ctrl.sv =====
// sequencer, cursor and sweep counter driving the screen ram
module ttw_ctrl import ttw_pkg::*; #(
   parameter int ROWS = DEF_ROWS,
   parameter int COLS = DEF_COLS
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_action,
   input  logic [7:0]     req_char_code,
   input  logic [4:0]     req_read_row,
   input  logic [6:0]     req_read_col,
   input  logic [7:0]     text_attribute,
   output logic           res_valid,
   output ttw_result_type res,
   input  logic           res_ready
);

   localparam int CELLS = ROWS * COLS;
   localparam int AW = $clog2(CELLS);
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
   localparam logic [AW-1:0] MOVE_END  = AW'((ROWS - 1) * COLS);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);
   localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);

   ttw_state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [1:0]    act_ff;
   logic [7:0]    code_ff;
   logic [4:0]    rrow_ff;
   logic [6:0]    rcol_ff;
   logic [15:0]   blank_ff;
   logic [15:0]   cell_ff;

   logic          accept;
   logic          is_ctrl_char;
   logic          row_adv;
   logic          need_scroll;
   logic          rd_ok;
   logic [31:0]   mul_row;
   logic [31:0]   mul_col;
   logic [AW-1:0] cell_addr;
   logic [RW+4:0] row_ext;
   logic [CW+6:0] col_ext;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [15:0]   ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [15:0]   ram_rdata;

   assign accept = req_valid && !req_stall;

   // put decode: control characters, line advance and scroll
   assign is_ctrl_char = (code_ff == CH_NEWLINE) || (code_ff == CH_RETURN);
   assign row_adv      = (code_ff == CH_NEWLINE) ||
                         (code_ff != CH_RETURN && col_ff == COL_LAST);
   assign need_scroll  = row_adv && (row_ff == ROW_LAST);

   // read range check
   assign rd_ok = (32'(rrow_ff) < ROWS) && (32'(rcol_ff) < COLS);

   // shared row * COLS + col address unit
   assign mul_row   = (state_ff == S_READ) ? 32'(rrow_ff) : 32'(row_ff);
   assign mul_col   = (state_ff == S_READ) ? 32'(rcol_ff) : 32'(col_ff);
   assign cell_addr = AW'(mul_row * COLS + mul_col);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (cnt_ff == LAST_ADDR) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_PUT:   state_in = S_PUT;
                  ACT_READ:  state_in = S_READ;
                  ACT_CLEAR: state_in = S_SWEEP;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_PUT: begin
            state_in = need_scroll ? S_SCROLL : S_DONE;
         end
         S_READ:  state_in = S_RDATA;
         S_RDATA: state_in = S_DONE;
         S_SCROLL: begin
            if (cnt_ff == MOVE_END) state_in = S_SWEEP;
         end
         S_SWEEP: begin
            if (cnt_ff == LAST_ADDR) state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // outputs: ram port, handshake
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = blank_ff;
      ram_raddr = cnt_ff + ROW_STEP;
      req_stall = (state_ff != S_IDLE);
      res_valid = (state_ff == S_DONE);
      unique case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = BLANK_RESET;
         end
         S_PUT: begin
            ram_we    = !is_ctrl_char;
            ram_waddr = cell_addr;
            ram_wdata = {text_attribute, code_ff};
         end
         S_READ: begin
            ram_raddr = cell_addr;
         end
         S_SCROLL: begin
            ram_we    = (cnt_ff != '0);
            ram_waddr = cnt_ff - AW'(1);
            ram_wdata = ram_rdata;
         end
         S_SWEEP: begin
            ram_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // cursor and sweep counter next values
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         S_INIT, S_SWEEP: begin
            cnt_in = cnt_ff + AW'(1);
         end
         S_IDLE: begin
            cnt_in = '0;
            if (accept && req_action == ACT_CLEAR) begin
               row_in = '0;
               col_in = '0;
            end
         end
         S_PUT: begin
            cnt_in = '0;
            if (is_ctrl_char || col_ff == COL_LAST) begin
               col_in = '0;
            end else begin
               col_in = col_ff + CW'(1);
            end
            if (row_adv && !need_scroll) begin
               row_in = row_ff + RW'(1);
            end
         end
         S_SCROLL: begin
            if (cnt_ff != MOVE_END) cnt_in = cnt_ff + AW'(1);
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   // request capture and read result
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_action;
         code_ff  <= req_char_code;
         rrow_ff  <= req_read_row;
         rcol_ff  <= req_read_col;
         blank_ff <= {text_attribute, CH_SPACE};
         cell_ff  <= '0;
      end else if (state_ff == S_RDATA && act_ff == ACT_READ) begin
         cell_ff <= rd_ok ? ram_rdata : 16'h0000;
      end
   end

   ttw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // response fields, cursor cut to the port widths
   assign row_ext = {5'b0, row_ff};
   assign col_ext = {7'b0, col_ff};
   assign res.cell_value = cell_ff;
   assign res.cursor_row = row_ext[4:0];
   assign res.cursor_col = col_ext[6:0];

endmodule

// ===== src/text_terminal_writer.sv =====
// top level of the text terminal writer: attribute register and response register
//
// A character screen of ROWS x COLS 16-bit cells (attribute high byte, character
// low byte) with a cursor. Requests arrive on req_* with valid/stall; action 0
// puts req_char_code at the cursor (newline and carriage return move the cursor),
// action 1 reads the cell at req_read_row/req_read_col, action 2 clears the
// screen. Every request gives one response on rsp_* with the cursor after it.
// csr_wr_en/csr_wr_data load the attribute used for written and blank cells.
// One request is in work at a time. A clear sweeps every cell with the blank
// cell; a put that scrolls first copies each row up one row, then blanks the
// bottom row. The screen ram has one write port and one registered read port.
// After reset a pass blanks the screen with attribute 0x0F; req_stall stays
// high until it ends. The response sits in an output register, so a new
// request is taken while rsp_stall holds the last one; the next response
// then waits in the sequencer until the register frees up.
module text_terminal_writer import ttw_pkg::*; #(
   parameter int ROWS = DEF_ROWS,
   parameter int COLS = DEF_COLS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_cell_value,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0]     attr_ff;
   logic           rsp_valid_ff;
   ttw_result_type rsp_ff;
   logic           res_valid;
   logic           res_ready;
   ttw_result_type res;

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_wr_en) begin
         attr_ff <= csr_wr_data;
      end
   end

   ttw_ctrl #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .text_attribute (attr_ff),
      .res_valid      (res_valid),
      .res            (res),
      .res_ready      (res_ready)
   );

   // response register
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_ff.cell_value;
   assign rsp_cursor_row = rsp_ff.cursor_row;
   assign rsp_cursor_col = rsp_ff.cursor_col;

   // screen clear pass holds off requests right after reset
   a_init_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during reset clear pass");

   // one request in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in work");

   // reported cursor row stays on the screen
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_row) < ROWS))
      else $error("cursor row beyond last row");

endmodule

// ===== tb/ttw_screen_check.sv =====
// response checker for the text terminal writer: screen predictor and comparison
`timescale 1ns / 1ps

module ttw_screen_check import ttw_pkg::*; #(
   parameter int ROWS = DEF_ROWS,
   parameter int COLS = DEF_COLS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_cell_value,
   input  logic [4:0]  rsp_cursor_row,
   input  logic [6:0]  rsp_cursor_col,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_count
);

   // predicted screen, cursor and attribute
   logic [15:0]    screen_model [ROWS*COLS];
   int             cur_row;
   int             cur_col;
   logic [7:0]     text_attr;
   ttw_result_type expected_results [$];

   // blank every cell with the current attribute and home the cursor
   function automatic void blank_screen();
      for (int i = 0; i < ROWS*COLS; i++) begin
         screen_model[i] = {text_attr, CH_SPACE};
      end
      cur_row = 0;
      cur_col = 0;
   endfunction

   // apply one request to the predicted screen and form its response
   function automatic ttw_result_type terminal_step(logic [1:0] act, logic [7:0] code,
                                                    logic [4:0] row, logic [6:0] col);
      ttw_result_type res;
      res.cell_value = '0;
      case (act)
         ACT_PUT: begin
            if (code == CH_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (code == CH_RETURN) begin
               cur_col = 0;
            end else begin
               screen_model[cur_row*COLS + cur_col] = {text_attr, code};
               cur_col++;
               // wrap at the right edge
               if (cur_col >= COLS) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            // past the last row: shift all rows up and blank the bottom one
            if (cur_row >= ROWS) begin
               for (int i = 0; i < (ROWS-1)*COLS; i++) begin
                  screen_model[i] = screen_model[i + COLS];
               end
               for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) begin
                  screen_model[i] = {text_attr, CH_SPACE};
               end
               cur_row = ROWS - 1;
            end
         end
         ACT_READ: begin
            // out of range reads give zero
            if (row < ROWS && col < COLS) begin
               res.cell_value = screen_model[row*COLS + col];
            end
         end
         ACT_CLEAR: begin
            blank_screen();
         end
         default: ;
      endcase
      res.cursor_row = cur_row[4:0];
      res.cursor_col = cur_col[6:0];
      return res;
   endfunction

   // watch both channels and the attribute port at each rising edge
   always @(posedge clock) begin
      ttw_result_type want;
      if (reset) begin
         text_attr = ATTR_RESET;
         blank_screen();
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            text_attr = csr_wr_data;
         end
         // compare the outgoing response with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_cell_value !== want.cell_value) begin
                  $error("cell_value: expected %h, got %h", want.cell_value, rsp_cell_value);
                  fail_count++;
               end
               if (rsp_cursor_row !== want.cursor_row) begin
                  $error("cursor_row: expected %0d, got %0d", want.cursor_row, rsp_cursor_row);
                  fail_count++;
               end
               if (rsp_cursor_col !== want.cursor_col) begin
                  $error("cursor_col: expected %0d, got %0d", want.cursor_col, rsp_cursor_col);
                  fail_count++;
               end
            end
         end
         // predict each accepted request
         if (req_valid && !req_stall) begin
            expected_results.push_back(terminal_step(req_action, req_char_code,
                                                     req_read_row, req_read_col));
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// ===== tb/tb_text_terminal_writer.sv =====
// testbench top for the text terminal writer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_text_terminal_writer;
   import ttw_pkg::*;

   localparam int ROWS = DEF_ROWS;
   localparam int COLS = DEF_COLS;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int LONG_HOLD = 300;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 290;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [7:0]  req_char_code;
   logic [4:0]  req_read_row;
   logic [6:0]  req_read_col;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_cell_value;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_col;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   int          fail_count;
   int          pending_count;

   // stimulus controls of the sender and the receiver
   bit quiet_mode = 1'b0;
   bit hold_request = 1'b0;
   int send_calm = 0;

   text_terminal_writer #(.ROWS(ROWS), .COLS(COLS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   ttw_screen_check #(.ROWS(ROWS), .COLS(COLS)) screen_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      #100_000_000;
      $display("FAIL");
      $finish;
   end

   // offer one request from a falling edge and hold it until it is taken
   task automatic send_request(input logic [1:0] act, input logic [7:0] code,
                               input logic [4:0] row, input logic [6:0] col);
      req_valid     <= 1'b1;
      req_action    <= act;
      req_char_code <= code;
      req_read_row  <= row;
      req_read_col  <= col;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      @(negedge clock);
   endtask

   // random gap between requests, with calm stretches
   task automatic sender_gap();
      if (quiet_mode) return;
      if (send_calm > 0) begin
         send_calm--;
         return;
      end
      if ($urandom_range(0, 49) == 0) begin
         send_calm = $urandom_range(20, 80);
      end else if ($urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // let the block drain, then load a new attribute
   task automatic settle_and_write(input logic [7:0] attr);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= attr;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // response side: short random stalls, calm stretches and one long hold
   initial begin : response_side
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (quiet_mode) begin
            rsp_stall <= 1'b0;
         end else if (calm_left > 0) begin
            rsp_stall <= 1'b0;
            calm_left--;
         end else if ($urandom_range(0, 39) == 0) begin
            rsp_stall <= 1'b0;
            calm_left = $urandom_range(30, 120);
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 6) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      logic [7:0] attr_plan [PHASES];
      int         pick;
      logic [1:0] act;
      logic [7:0] code;
      logic [4:0] row;
      logic [6:0] col;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_PUT;
      req_char_code = 8'h00;
      req_read_row  = 5'd0;
      req_read_col  = 7'd0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 8'h00;
      attr_plan = '{8'h07, 8'h00, 8'hFF, 8'h00, 8'h0F, 8'h00};
      attr_plan[3] = 8'($urandom_range(0, 255));
      attr_plan[5] = 8'($urandom_range(0, 255));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset contents, corners, out of range reads and the unused action
      send_request(ACT_READ, 8'h00, 5'd0, 7'd0);
      send_request(ACT_READ, 8'hFF, 5'd24, 7'd79);
      sender_gap();
      send_request(ACT_READ, 8'h00, 5'd25, 7'd0);
      send_request(ACT_READ, 8'h00, 5'd0, 7'd80);
      send_request(ACT_READ, 8'h00, 5'd31, 7'd127);
      send_request(ACT_UNUSED, 8'hFF, 5'd31, 7'd127);
      sender_gap();
      // puts: extreme bytes, carriage return and newline
      send_request(ACT_PUT, 8'h41, 5'd31, 7'd127);
      send_request(ACT_PUT, 8'h00, 5'd0, 7'd0);
      send_request(ACT_PUT, 8'hFF, 5'd0, 7'd0);
      send_request(ACT_PUT, CH_RETURN, 5'd0, 7'd0);
      sender_gap();
      send_request(ACT_PUT, 8'h42, 5'd0, 7'd0);
      send_request(ACT_PUT, CH_NEWLINE, 5'd0, 7'd0);
      send_request(ACT_PUT, 8'h43, 5'd0, 7'd0);
      send_request(ACT_READ, 8'h00, 5'd0, 7'd0);
      send_request(ACT_READ, 8'h00, 5'd0, 7'd1);
      send_request(ACT_READ, 8'h00, 5'd1, 7'd0);

      // attribute change leaves stored cells alone
      settle_and_write(8'h00);
      send_request(ACT_PUT, 8'h7E, 5'd0, 7'd0);
      send_request(ACT_READ, 8'h00, 5'd1, 7'd1);
      send_request(ACT_READ, 8'h00, 5'd0, 7'd0);

      // clear with a full attribute
      settle_and_write(8'hFF);
      send_request(ACT_CLEAR, 8'h55, 5'd10, 7'd10);
      send_request(ACT_READ, 8'h00, 5'd24, 7'd79);
      send_request(ACT_READ, 8'h00, 5'd0, 7'd0);
      send_request(ACT_PUT, 8'h5A, 5'd0, 7'd0);
      send_request(ACT_READ, 8'h00, 5'd0, 7'd0);

      // random phases, each under its own attribute
      for (int p = 0; p < PHASES; p++) begin
         settle_and_write(attr_plan[p]);
         if (p == PHASES - 1) quiet_mode = 1'b1;
         // receiver holds off while the sender keeps offering requests
         if (p == 1) begin
            hold_request = 1'b1;
            send_calm = 80;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 999);
            code = 8'($urandom_range(0, 255));
            row  = 5'($urandom_range(0, 31));
            col  = 7'($urandom_range(0, 127));
            if (pick < 4) begin
               act = ACT_CLEAR;
            end else if (pick < 600) begin
               act = ACT_PUT;
               if ($urandom_range(0, 9) != 0) code = 8'($urandom_range(32, 126));
            end else if (pick < 700) begin
               act = ACT_PUT;
               code = CH_NEWLINE;
            end else if (pick < 740) begin
               act = ACT_PUT;
               code = CH_RETURN;
            end else if (pick < 900) begin
               // in range reads, biased toward the bottom rows where text lands
               act = ACT_READ;
               row = 5'($urandom_range(0, 1) ? $urandom_range(ROWS - 5, ROWS - 1)
                                             : $urandom_range(0, ROWS - 1));
               col = 7'($urandom_range(0, COLS - 1));
            end else if (pick < 950) begin
               act = ACT_READ;
               if ($urandom_range(0, 1)) row = 5'($urandom_range(ROWS, 31));
               else col = 7'($urandom_range(COLS, 127));
            end else begin
               act = ACT_UNUSED;
            end
            send_request(act, code, row, col);
            sender_gap();
         end
      end

      // drain and give the verdict
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
